/* rtl/core/stg_pkg.sv */
// shared types, register map and sine table builder for the sine tone generator
package stg_pkg;

   // register map, index of each register in the csr block
   localparam logic [1:0] REG_PHASE_STEP   = 2'd0;
   localparam logic [1:0] REG_SAMPLE_LIMIT = 2'd1;
   localparam logic [1:0] REG_RUN_FOREVER  = 2'd2;

   localparam int unsigned CSR_ADDR_W = 4;

   // unity volume in q1.15
   localparam logic [15:0] VOL_ONE = 16'h8000;

   // pi/2 in q30 and the taylor denominators (n+1)(n+2) for n = 1, 3, .. 17
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam int unsigned TAYLOR_TERMS = 9;
   localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
      64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
   };

   typedef struct packed {
      logic        restart;
      logic [15:0] master_volume;
   } req_type;

   typedef struct packed {
      logic signed [15:0] sample;
      logic               last;
   } rsp_type;

   typedef struct packed {
      logic [31:0] phase_step;
      logic [31:0] sample_limit;
      logic        run_forever;
   } cfg_type;

   // one looked-up sample on its way to the scaler
   typedef struct packed {
      logic [14:0] mag;
      logic        neg;
      logic [15:0] vol;
      logic        last;
   } mid_type;

   // quarter-wave entry k of a table with 2^qbits steps per quarter, built at elaboration
   function automatic logic [14:0] sine_entry(input int unsigned k, input int unsigned qbits);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic [63:0]        v;
      logic signed [63:0] sum;
      logic               minus;
      x     = (HALF_PI_Q30 * 64'(k)) >> qbits;
      x2    = (x * x) >> 30;
      term  = x;
      sum   = $signed(x);
      minus = 1'b1;
      for (int i = 0; i < TAYLOR_TERMS; i++) begin
         term = ((term * x2) >> 30) / TAYLOR_DIV[i];
         if (minus) begin
            sum = sum - $signed(term);
         end else begin
            sum = sum + $signed(term);
         end
         minus = !minus;
      end
      if (sum < 0) begin
         sum = '0;
      end
      v = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (v > 64'd32767) begin
         v = 64'd32767;
      end
      return v[14:0];
   endfunction

endpackage

/* rtl/core/stg_csr.sv */
// configuration registers behind the apb-style port
module stg_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [stg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready,
   output stg_pkg::cfg_type                cfg
);
   import stg_pkg::*;

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [1:0] reg_idx;

   assign reg_idx = paddr[3:2];
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            REG_PHASE_STEP:   cfg_in.phase_step   = pwdata;
            REG_SAMPLE_LIMIT: cfg_in.sample_limit = pwdata;
            REG_RUN_FOREVER:  cfg_in.run_forever  = pwdata[0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_idx)
         REG_PHASE_STEP:   prdata = cfg_ff.phase_step;
         REG_SAMPLE_LIMIT: prdata = cfg_ff.sample_limit;
         REG_RUN_FOREVER:  prdata = {31'd0, cfg_ff.run_forever};
         default:          prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

/* rtl/core/stg_seq.sv */
// tone state (phase, count, chunk) and quarter-wave sine lookup into the middle register
module stg_seq #(
   parameter int unsigned CHUNK_SIZE      = 240,
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  logic              clock,
   input  logic              reset,
   input  stg_pkg::cfg_type  cfg,
   input  logic              accept,
   input  logic              load,
   input  stg_pkg::req_type  req,
   output logic              mid_valid,
   output stg_pkg::mid_type  mid
);
   import stg_pkg::*;

   localparam int unsigned QBITS = SINE_TABLE_BITS - 2;
   localparam int unsigned QSIZE = 1 << QBITS;
   localparam int unsigned POS_W = $clog2(CHUNK_SIZE + 1);
   localparam logic [QBITS:0]   QUARTER_TOP = (QBITS + 1)'(QSIZE);
   localparam logic [POS_W-1:0] CHUNK_END   = POS_W'(CHUNK_SIZE);

   logic [14:0] quarter_tab [QSIZE+1];

   for (genvar g = 0; g <= QSIZE; g++) begin : g_tab
      localparam logic [14:0] ENTRY = sine_entry(g, QBITS);
      assign quarter_tab[g] = ENTRY;
   end

   logic [31:0]      phase_ff, phase_in;
   logic [31:0]      done_ff, done_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [15:0]      cvol_ff, cvol_in;
   logic             mid_valid_ff, mid_valid_in;
   mid_type          mid_ff, mid_in;

   logic [31:0]          phase_cur, done_cur, done_inc;
   logic [POS_W-1:0]     pos_cur, pos_inc;
   logic [15:0]          vol_sat, cvol_use;
   logic                 emit;
   logic [SINE_TABLE_BITS-1:0] tab_idx;
   logic [1:0]           quad;
   logic [QBITS-1:0]     kq;
   logic [QBITS:0]       tab_addr;

   always_comb begin
      phase_cur = req.restart ? '0 : phase_ff;
      done_cur  = req.restart ? '0 : done_ff;
      pos_cur   = req.restart ? '0 : pos_ff;
      vol_sat   = (req.master_volume > VOL_ONE) ? VOL_ONE : req.master_volume;
      emit      = cfg.run_forever || (done_cur < cfg.sample_limit);
      done_inc  = done_cur + 32'd1;
      pos_inc   = pos_cur + POS_W'(1);
      cvol_use  = (pos_cur == '0) ? vol_sat : cvol_ff;

      // quadrant folding of the table address
      tab_idx  = phase_cur[31 -: SINE_TABLE_BITS];
      quad     = tab_idx[SINE_TABLE_BITS-1 -: 2];
      kq       = tab_idx[QBITS-1:0];
      tab_addr = quad[0] ? (QUARTER_TOP - {1'b0, kq}) : {1'b0, kq};
   end

   always_comb begin
      phase_in = phase_ff;
      done_in  = done_ff;
      pos_in   = pos_ff;
      cvol_in  = cvol_ff;
      if (accept) begin
         phase_in = emit ? (phase_cur + cfg.phase_step) : phase_cur;
         done_in  = emit ? done_inc : done_cur;
         pos_in   = emit ? ((pos_inc >= CHUNK_END) ? '0 : pos_inc) : pos_cur;
         cvol_in  = emit ? cvol_use : cvol_ff;
      end
   end

   always_comb begin
      mid_valid_in = load ? (accept && emit) : mid_valid_ff;
      mid_in       = mid_ff;
      if (load) begin
         mid_in.mag  = quarter_tab[tab_addr];
         mid_in.neg  = quad[1];
         mid_in.vol  = cvol_use;
         mid_in.last = !cfg.run_forever && (done_inc == cfg.sample_limit);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         done_ff      <= '0;
         pos_ff       <= '0;
         cvol_ff      <= '0;
         mid_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         done_ff      <= done_in;
         pos_ff       <= pos_in;
         cvol_ff      <= cvol_in;
         mid_valid_ff <= mid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      mid_ff <= mid_in;
   end

   assign mid_valid = mid_valid_ff;
   assign mid       = mid_ff;

endmodule

/* rtl/core/stg_scale.sv */
// volume scaling with truncation toward zero and the result register
module stg_scale (
   input  logic              clock,
   input  logic              reset,
   input  logic              advance,
   input  logic              mid_valid,
   input  stg_pkg::mid_type  mid,
   output logic              out_valid,
   output stg_pkg::rsp_type  out_data
);
   import stg_pkg::*;

   logic        out_valid_ff, out_valid_in;
   rsp_type     out_ff, out_in;
   logic [30:0] prod;
   logic [15:0] scaled;

   // scaling the magnitude keeps the truncation toward zero
   assign prod   = 31'(mid.vol) * 31'(mid.mag);
   assign scaled = prod[30:15];

   always_comb begin
      out_valid_in = advance ? mid_valid : out_valid_ff;
      out_in       = out_ff;
      if (advance) begin
         out_in.sample = mid.neg ? -$signed(scaled) : $signed(scaled);
         out_in.last   = mid.last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule

/* rtl/core/sine_tone_generator_core.sv */
// top level of the sine tone generator: dds phase accumulator, sine lookup, volume scaling
//
// Direct digital synthesis sine oscillator. Every req beat is one sample tick carrying a restart
// flag and the live master volume (q1.15, values above 1.0 clip to 1.0). Restart clears the
// phase, the sample count and the chunk position before the tick is used. The volume is taken
// only on the first sample of each chunk of CHUNK_SIZE samples. The 32-bit phase advances by
// phase_step per sample; its top SINE_TABLE_BITS bits address a quarter-wave table of
// 2^(SINE_TABLE_BITS-2)+1 entries built at elaboration (no clearing pass, no ram). In counted
// mode (run_forever = 0) a tick after sample_limit samples gives no rsp beat and changes
// nothing, and the final sample carries last. Rate: one req beat per clock while rsp_stall is
// low; phase and count update is a single add per cycle. An accepted req beat reaches rsp via
// the lookup register, then the scaling/result register. No-sample ticks are still accepted. The
// user writes configuration only while the block is idle; the block does not enforce it.
module sine_tone_generator_core #(
   parameter int unsigned CHUNK_SIZE      = 240,
   parameter int unsigned SINE_TABLE_BITS = 10
) (
   input  logic                            clock,
   input  logic                            reset,
   // sample tick channel
   input  logic                            req_valid,
   output logic                            req_stall,
   input  stg_pkg::req_type                req_data,
   // sample result channel
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output stg_pkg::rsp_type                rsp_data,
   // configuration port
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [stg_pkg::CSR_ADDR_W-1:0]  paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);
   import stg_pkg::*;

   cfg_type cfg;
   mid_type mid;
   logic    mid_valid;
   logic    advance;   // result register may load
   logic    mid_load;  // lookup register may load
   logic    accept;

   // the result register frees up when empty or when its beat is taken this cycle
   assign advance   = !rsp_valid || !rsp_stall;
   assign mid_load  = !mid_valid || advance;
   assign req_stall = !mid_load;
   assign accept    = req_valid && mid_load;

   stg_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // state update and table lookup happen at the accepting edge
   stg_seq #(
      .CHUNK_SIZE      (CHUNK_SIZE),
      .SINE_TABLE_BITS (SINE_TABLE_BITS)
   ) u_seq (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .accept    (accept),
      .load      (mid_load),
      .req       (req_data),
      .mid_valid (mid_valid),
      .mid       (mid)
   );

   // volume times sine into the result register
   stg_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .mid_valid (mid_valid),
      .mid       (mid),
      .out_valid (rsp_valid),
      .out_data  (rsp_data)
   );

   // the table peaks at 32767, so the most negative code never shows up
   a_no_min_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.sample != 16'sh8000)
      else $error("sample hit the most negative code");

   // a pending lookup result is never dropped while the output is blocked
   a_mid_held: assert property (@(posedge clock) disable iff (reset)
      mid_valid && rsp_valid && rsp_stall |=> mid_valid)
      else $error("lookup beat lost under output stall");

   // an output beat is not repeated when nothing is behind it
   a_no_repeat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !mid_valid |=> !rsp_valid)
      else $error("result beat repeated");

endmodule

/* tb/sv/tone_check_pkg.sv */
// scoreboard class holding the tone predictor and the queue of samples still due
package tone_check_pkg;

   localparam int unsigned CHUNK_LEN       = 240;
   localparam int unsigned TABLE_BITS      = 10;
   localparam int unsigned QUARTER_LEN     = 1 << (TABLE_BITS - 2);
   localparam longint unsigned RIGHT_ANGLE_Q30 = 64'd1686629713;
   localparam int unsigned REPORT_LIMIT    = 10;

   class tone_scoreboard;
      // register copies
      logic [31:0]      phase_step;
      logic [31:0]      sample_limit;
      logic             run_forever;
      // oscillator state
      logic [31:0]      phase_acc;
      logic [31:0]      samples_done;
      logic [7:0]       chunk_pos;
      logic [15:0]      chunk_vol;
      logic [14:0]      quarter_wave [QUARTER_LEN + 1];
      stg_pkg::rsp_type samples_due [$];
      int unsigned      ticks;
      int unsigned      restarts;
      int unsigned      samples_checked;
      int unsigned      lasts_checked;
      int unsigned      errors;

      function new();
         for (int k = 0; k <= QUARTER_LEN; k++) begin
            quarter_wave[k] = taylor_sine(k);
         end
         phase_step      = '0;
         sample_limit    = '0;
         run_forever     = 1'b0;
         phase_acc       = '0;
         samples_done    = '0;
         chunk_pos       = '0;
         chunk_vol       = '0;
         ticks           = 0;
         restarts        = 0;
         samples_checked = 0;
         lasts_checked   = 0;
         errors          = 0;
      endfunction

      // fixed-point taylor series of sin(k/quarter * pi/2), scaled to 32767
      function logic [14:0] taylor_sine(int unsigned k);
         longint unsigned ang;
         longint unsigned ang_sq;
         longint unsigned term;
         longint unsigned scaled;
         longint          acc;
         bit              subtract;
         ang      = (RIGHT_ANGLE_Q30 * 64'(k)) >> (TABLE_BITS - 2);
         ang_sq   = (ang * ang) >> 30;
         term     = ang;
         acc      = longint'(ang);
         subtract = 1'b1;
         for (int n = 1; n < 19; n += 2) begin
            term = ((term * ang_sq) >> 30) / 64'((n + 1) * (n + 2));
            acc  = subtract ? acc - longint'(term) : acc + longint'(term);
            subtract = !subtract;
         end
         if (acc < 0) begin
            acc = 0;
         end
         scaled = ($unsigned(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
         if (scaled > 64'd32767) begin
            scaled = 64'd32767;
         end
         return 15'(scaled);
      endfunction

      function void set_reg(logic [1:0] which, logic [31:0] value);
         case (which)
            stg_pkg::REG_PHASE_STEP: begin
               phase_step = value;
            end
            stg_pkg::REG_SAMPLE_LIMIT: begin
               sample_limit = value;
            end
            stg_pkg::REG_RUN_FOREVER: begin
               run_forever = value[0];
            end
            default: begin
            end
         endcase
      endfunction

      function bit tone_over();
         return !run_forever && (samples_done >= sample_limit);
      endfunction

      // one accepted tick beat, queues the sample it makes if any
      function void note_tick(stg_pkg::req_type item);
         logic [15:0]      vol;
         logic [9:0]       idx;
         logic [14:0]      mag;
         logic [30:0]      scaled;
         stg_pkg::rsp_type due;
         ticks++;
         vol = (item.master_volume > stg_pkg::VOL_ONE) ? stg_pkg::VOL_ONE : item.master_volume;
         if (item.restart) begin
            phase_acc    = '0;
            samples_done = '0;
            chunk_pos    = '0;
            restarts++;
         end
         if (tone_over()) begin
            return;
         end
         if (chunk_pos == 0) begin
            chunk_vol = vol;
         end
         chunk_pos = (chunk_pos + 1 >= CHUNK_LEN) ? 8'd0 : chunk_pos + 8'd1;
         idx = phase_acc[31 -: TABLE_BITS];
         if (idx[TABLE_BITS-2]) begin
            mag = quarter_wave[QUARTER_LEN - idx[TABLE_BITS-3:0]];
         end else begin
            mag = quarter_wave[idx[TABLE_BITS-3:0]];
         end
         scaled     = (31'(chunk_vol) * 31'(mag)) >> 15;
         due.sample = 16'(scaled);
         if (idx[TABLE_BITS-1]) begin
            due.sample = -due.sample;
         end
         phase_acc    = phase_acc + phase_step;
         samples_done = samples_done + 32'd1;
         due.last     = !run_forever && (samples_done == sample_limit);
         samples_due.push_back(due);
      endfunction

      function void flag(string msg);
         errors++;
         if (errors <= REPORT_LIMIT) begin
            $display("ERROR: %s", msg);
         end
      endfunction

      function void check_sample(stg_pkg::rsp_type got);
         stg_pkg::rsp_type want;
         if (samples_due.size() == 0) begin
            flag($sformatf("sample beat with nothing pending: sample %0d last %0b",
                           got.sample, got.last));
            return;
         end
         want = samples_due.pop_front();
         samples_checked++;
         if (got.sample !== want.sample) begin
            flag($sformatf("sample %0d: sample expected %0d, got %0d",
                           samples_checked, want.sample, got.sample));
         end
         if (got.last !== want.last) begin
            flag($sformatf("sample %0d: last expected %0b, got %0b",
                           samples_checked, want.last, got.last));
         end
         if (want.last) begin
            lasts_checked++;
         end
      endfunction

      function int unsigned pending();
         return samples_due.size();
      endfunction

      function void finish_check();
         if (samples_due.size() != 0) begin
            flag($sformatf("%0d expected samples never arrived", samples_due.size()));
         end
      endfunction
   endclass

endpackage

/* tb/sv/tb_sine_tone_generator_core.sv */
// top of the sine tone generator testbench: clock, reset, drivers, monitor and run control
module tb_sine_tone_generator_core;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned RANDOM_PHASES = 8;
   localparam int unsigned PHASE_TICKS   = 150;
   // idle clocks after the last sample before touching registers
   localparam int unsigned SETTLE_CYCLES = 4;

   logic                            clock = 1'b0;
   logic                            reset;
   logic                            req_valid;
   logic                            req_stall;
   stg_pkg::req_type                req_data;
   logic                            rsp_valid;
   logic                            rsp_stall;
   stg_pkg::rsp_type                rsp_data;
   logic                            psel;
   logic                            penable;
   logic                            pwrite;
   logic [stg_pkg::CSR_ADDR_W-1:0]  paddr;
   logic [31:0]                     pwdata;
   logic [31:0]                     prdata;
   logic                            pready;

   // idling switches, changed per phase so some stretches run without gaps
   bit                              idle_on;
   bit                              stall_on;
   int unsigned                     settings_used;

   tone_check_pkg::tone_scoreboard  sb;

   sine_tone_generator_core #(
      .CHUNK_SIZE      (tone_check_pkg::CHUNK_LEN),
      .SINE_TABLE_BITS (tone_check_pkg::TABLE_BITS)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // idle length: a short draw 85 percent of the time, else a long one
   function automatic int unsigned idle_len();
      if ($urandom_range(0, 99) < 85) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // volume: mostly legal q1.15, some above unity, some corner values
   function automatic logic [15:0] pick_volume();
      case ($urandom_range(0, 19))
         0, 1, 2: begin
            return 16'($urandom());
         end
         3: begin
            return 16'h0000;
         end
         4: begin
            return stg_pkg::VOL_ONE;
         end
         5: begin
            return 16'hFFFF;
         end
         default: begin
            return 16'($urandom_range(0, 32768));
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_step();
      case ($urandom_range(0, 5))
         0: begin
            return $urandom();
         end
         1: begin
            return $urandom_range(0, 32'h00FF_FFFF);
         end
         2: begin
            // audible tone at a 12 khz sample rate
            return 32'((64'($urandom_range(20, 6000)) << 32) / 64'd12000);
         end
         3: begin
            return 32'hFFFF_FFFF;
         end
         4: begin
            return 32'h8000_0000;
         end
         default: begin
            return 32'h0;
         end
      endcase
   endfunction

   function automatic logic [31:0] pick_limit();
      case ($urandom_range(0, 5))
         0: begin
            return $urandom_range(1, 400);
         end
         1: begin
            return 32'h0;
         end
         2: begin
            return 32'hFFFF_FFFF;
         end
         3: begin
            return $urandom();
         end
         4: begin
            return 32'h1;
         end
         default: begin
            return $urandom_range(200, 600);
         end
      endcase
   endfunction

   // one tick beat; entered and left at a falling edge
   task automatic send_tick(input bit restart, input logic [15:0] volume);
      stg_pkg::req_type item;
      int unsigned      gap;
      item.restart       = restart;
      item.master_volume = volume;
      gap = (idle_on && $urandom_range(0, 2) == 0) ? idle_len() : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (req_stall) begin
         @(posedge clock);
      end
      sb.note_tick(item);
      @(negedge clock);
   endtask

   // drop valid, wait for every sample, then let the pipe run dry
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // apb write: setup cycle, then access until pready, then back to idle
   task automatic csr_write(input logic [1:0] which, input logic [31:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {which, 2'b00};
      pwdata  <= value;
      @(negedge clock);
      penable <= 1'b1;
      @(posedge clock);
      while (!pready) begin
         @(posedge clock);
      end
      sb.set_reg(which, value);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(negedge clock);
   endtask

   task automatic configure(input logic [31:0] step, input logic [31:0] limit,
                            input bit forever_on);
      csr_write(stg_pkg::REG_PHASE_STEP, step);
      csr_write(stg_pkg::REG_SAMPLE_LIMIT, limit);
      csr_write(stg_pkg::REG_RUN_FOREVER, {31'd0, forever_on});
      settings_used++;
   endtask

   // result side stall: alternating free and stalled segments of random length
   initial begin
      int unsigned hold;
      bit          stalling;
      hold      = 0;
      stalling  = 1'b0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold == 0) begin
            stalling = stall_on && ($urandom_range(0, 3) == 0);
            hold     = stalling ? idle_len() : $urandom_range(1, 12);
         end
         rsp_stall <= stalling;
         hold--;
      end
   end

   // every sample beat is checked against the oldest expected sample
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         sb.check_sample(rsp_data);
      end
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #20ms;
      $display("sine_tone_generator_core: mismatch");
      $finish;
   end

   initial begin
      bit restart;
      sb            = new();
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      psel          = 1'b0;
      penable       = 1'b0;
      pwrite        = 1'b0;
      paddr         = '0;
      pwdata        = '0;
      idle_on       = 1'b1;
      stall_on      = 1'b1;
      settings_used = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // counted tone of six samples, step of 1/256 turn stays in the first quadrant;
      // volume extremes including values above unity, then ticks past the end
      configure(32'h0100_0000, 32'd6, 1'b0);
      send_tick(1'b1, stg_pkg::VOL_ONE);
      send_tick(1'b0, 16'hFFFF);
      send_tick(1'b0, 16'h0000);
      send_tick(1'b0, 16'h0001);
      send_tick(1'b0, 16'h7FFF);
      send_tick(1'b0, 16'h8001);
      // finished tone: the first two make nothing, the restart starts a new tone
      send_tick(1'b0, stg_pkg::VOL_ONE);
      send_tick(1'b0, 16'hFFFF);
      send_tick(1'b1, 16'hFFFF);
      settle();

      // zero limit in counted mode: even a restart makes no sample
      configure(32'h0100_0000, 32'd0, 1'b0);
      send_tick(1'b1, stg_pkg::VOL_ONE);
      send_tick(1'b0, stg_pkg::VOL_ONE);
      settle();

      // single-sample tone carries last, then the tone is over
      configure(32'hFFFF_FFFF, 32'd1, 1'b0);
      send_tick(1'b1, stg_pkg::VOL_ONE);
      send_tick(1'b0, stg_pkg::VOL_ONE);
      settle();

      // switch to infinite mode without a restart, quarter-turn steps from the leftover phase land
      // just short of the quadrant boundaries
      configure(32'h4000_0000, 32'd1, 1'b1);
      repeat (5) send_tick(1'b0, stg_pkg::VOL_ONE);
      send_tick(1'b1, 16'd12345);
      settle();

      // random phases: first two pin the register extremes, the rest are drawn
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         idle_on  = (p % 3) != 2;
         stall_on = (p % 4) != 3;
         if (p == 0) begin
            configure(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
         end else if (p == 1) begin
            configure(32'h0, 32'h0, 1'b1);
         end else begin
            configure(pick_step(), pick_limit(), 1'($urandom_range(0, 1)));
         end
         for (int i = 0; i < PHASE_TICKS; i++) begin
            // restarts are rare while a tone runs, frequent once it has ended
            if (sb.tone_over()) begin
               restart = ($urandom_range(0, 7) == 0);
            end else begin
               restart = ($urandom_range(0, 79) == 0);
            end
            send_tick(restart, pick_volume());
         end
         settle();
      end

      sb.finish_check();
      $display("covered %0d tick beats with %0d restarts over %0d register settings",
               sb.ticks, sb.restarts, settings_used);
      $display("checked %0d sample beats, %0d of them flagged last, %0d errors",
               sb.samples_checked, sb.lasts_checked, sb.errors);
      if (sb.errors == 0) begin
         $display("sine_tone_generator_core: match");
      end else begin
         $display("sine_tone_generator_core: mismatch");
      end
      $finish;
   end

endmodule
